[rtl/adsr_envelope_generator_macros.svh]
// Assertion macros for the ADSR envelope generator RTL.
`ifndef ADSR_ENVELOPE_GENERATOR_MACROS_SVH
`define ADSR_ENVELOPE_GENERATOR_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define ADSR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("adsr check failed");
// Next-cycle implication, checked out of reset.
`define ADSR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("adsr check failed");
`else
`define ADSR_ASSERT_IMP(lbl, ante, cons)
`define ADSR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/adsr_pkg.sv]
// Shared constants, codes and types of the ADSR envelope generator.
`default_nettype none
package adsr_pkg;

	// elapsed counter width, also the width of the segment lengths
	localparam int TIME_BITS = 20;
	// divider numerator: length-wide multiplicand times a Q1.15 factor
	localparam int NUM_W     = TIME_BITS + 16;
	localparam int LVL_W     = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
	localparam logic [LVL_W-1:0]     ONE_Q15  = 16'h8000;

	// register reset values
	localparam logic [TIME_BITS-1:0] ATTACK_RST  = TIME_BITS'(19845);
	localparam logic [TIME_BITS-1:0] DECAY_RST   = TIME_BITS'(30870);
	localparam logic [TIME_BITS-1:0] HOLD_RST    = TIME_BITS'(88200);
	localparam logic [LVL_W-1:0]     LEVEL_RST   = 16'd16384;
	localparam logic [TIME_BITS-1:0] RELEASE_RST = TIME_BITS'(79380);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd4;

	// envelope segments, walked in order
	typedef enum logic [1:0] {
		SEG_ATTACK  = 2'd0,
		SEG_DECAY   = 2'd1,
		SEG_HOLD    = 2'd2,
		SEG_RELEASE = 2'd3
	} seg_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEG,
		ST_NUM_MUL,
		ST_DIV,
		ST_SCALE,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

[rtl/adsr_divider.sv]
// Restoring divider, one quotient bit per cycle, for a quotient below 2^16.
`default_nettype none
module adsr_divider (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [adsr_pkg::NUM_W-1:0]        numer,
	input  wire logic [adsr_pkg::TIME_BITS-1:0]    divisor,
	output logic                                   done,
	output logic [adsr_pkg::LVL_W-1:0]             quotient
);

	localparam int TB = adsr_pkg::TIME_BITS;
	localparam int QW = adsr_pkg::LVL_W;

	logic          busy_q;
	logic          done_q;
	logic [3:0]    cnt_q;
	logic [TB-1:0] rem_q;
	logic [TB-1:0] div_q;
	logic [QW-1:0] quo_q;

	logic [TB:0]   trial;
	logic [TB:0]   diff;
	logic          qbit;

	// trial subtract of the divisor from remainder with next numerator bit
	always_comb begin
		trial = {rem_q, quo_q[QW-1]};
		diff  = trial - {1'b0, div_q};
		qbit  = (trial >= {1'b0, div_q});
	end

	// control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'(QW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: high numerator part is below the divisor, so it seeds the remainder
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= numer[adsr_pkg::NUM_W-1:QW];
			quo_q <= numer[QW-1:0];
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[TB-1:0] : trial[TB-1:0];
			quo_q <= {quo_q[QW-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

[rtl/adsr_envelope_generator.sv]
// Linear ADSR envelope generator: top level with sequencer and shared multiplier.
//
// Input stream s_*: one beat per audio sample, tdata = {audio_in, trigger_sample}.
// A trigger above zero after a step where it was not restarts the envelope;
// otherwise the elapsed-sample counter advances and saturates (silence).
// Output stream m_*: one beat per input beat, tdata = {audio_out, envelope_level}.
// Config channel cfg_*: index 0..4 selects attack, decay, hold length, sustain
// level, release length; always ready; other indexes are ignored. Write it
// only while the block is idle.
// Timing: one sample at a time. The segment walk tests the segments in order
// (up to 4); a ramp segment then passes through the multiplier and the
// restoring divider (16 quotient bits); a scale step registers the audio
// product and a last step loads the output register. A saturated counter
// skips the walk and the ramp. Once the output register is loaded, the
// sequencer returns to idle and takes the next sample.
// s_tready is high only while the sequencer is idle. If the receiver stalls,
// the block holds a finished result until the output register frees up.
// Reset loads the default register values, saturates the counter and clears
// the trigger history, so the first outputs are silent.
`default_nettype none
`include "adsr_envelope_generator_macros.svh"
module adsr_envelope_generator (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input stream
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [31:0]                         s_tdata,   // [15:0] trigger_sample, [31:16] audio_in
	// output stream
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [31:0]                              m_tdata,   // [15:0] envelope_level, [31:16] audio_out
	// configuration writes
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [adsr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [adsr_pkg::TIME_BITS-1:0]      cfg_data
);

	localparam int TB = adsr_pkg::TIME_BITS;
	localparam int LW = adsr_pkg::LVL_W;
	localparam int PW = TB + 1 + LW + 1;

	// configuration registers
	logic [TB-1:0] attack_q, decay_q, hold_q, release_q;
	logic [LW-1:0] sus_q;

	// envelope state
	logic [TB-1:0] elapsed_q;
	logic          prev_pos_q;

	// sequencer and working registers
	adsr_pkg::state_t state_q, state_d;
	adsr_pkg::seg_t   seg_q;
	logic [TB-1:0]    t_q;
	logic [LW-1:0]    audio_q;
	logic [LW-1:0]    base_q;
	logic [TB-1:0]    divisor_q;
	logic signed [TB:0] mul_a_q;
	logic signed [LW:0] mul_b_q;
	logic signed [PW-1:0] prod_q;

	// output register
	logic          out_valid_q;
	logic [LW-1:0] out_level_q;
	logic [LW-1:0] out_audio_q;

	logic          in_beat;
	logic          cfg_beat;
	logic          trig_pos;
	logic [TB-1:0] elapsed_nxt;
	logic [TB-1:0] len_sel;
	logic          seg_hit;
	logic signed [PW-1:0] product;
	logic          div_start;
	logic          div_done;
	logic [LW-1:0] quotient;
	logic [LW:0]   level_sum;
	logic          out_free;

	assign cfg_ready = 1'b1;
	assign cfg_beat  = cfg_valid & cfg_ready;
	assign in_beat   = s_tvalid & s_tready;
	assign out_free  = ~out_valid_q | m_tready;

	// register writes; sustain level clamps to one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= adsr_pkg::ATTACK_RST;
			decay_q   <= adsr_pkg::DECAY_RST;
			hold_q    <= adsr_pkg::HOLD_RST;
			sus_q     <= adsr_pkg::LEVEL_RST;
			release_q <= adsr_pkg::RELEASE_RST;
		end else if (cfg_beat) begin
			case (cfg_index)
				adsr_pkg::CFG_ATTACK:  attack_q  <= cfg_data;
				adsr_pkg::CFG_DECAY:   decay_q   <= cfg_data;
				adsr_pkg::CFG_HOLD:    hold_q    <= cfg_data;
				adsr_pkg::CFG_LEVEL: begin
					sus_q <= (cfg_data[LW-1:0] > adsr_pkg::ONE_Q15) ?
						adsr_pkg::ONE_Q15 : cfg_data[LW-1:0];
				end
				adsr_pkg::CFG_RELEASE: release_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// counter step: restart on rising trigger, else saturating increment
	always_comb begin
		trig_pos = ~s_tdata[15] & (s_tdata[15:0] != '0);
		if (~prev_pos_q & trig_pos)
			elapsed_nxt = '0;
		else if (elapsed_q == adsr_pkg::TIME_MAX)
			elapsed_nxt = elapsed_q;
		else
			elapsed_nxt = elapsed_q + TB'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q  <= adsr_pkg::TIME_MAX;
			prev_pos_q <= 1'b0;
		end else if (in_beat) begin
			elapsed_q  <= elapsed_nxt;
			prev_pos_q <= trig_pos;
		end
	end

	// length of the segment under test
	always_comb begin
		case (seg_q)
			adsr_pkg::SEG_ATTACK:  len_sel = attack_q;
			adsr_pkg::SEG_DECAY:   len_sel = decay_q;
			adsr_pkg::SEG_HOLD:    len_sel = hold_q;
			adsr_pkg::SEG_RELEASE: len_sel = release_q;
			default:               len_sel = attack_q;
		endcase
		seg_hit = (t_q < len_sel);
	end

	// the one shared multiplier: ramp numerator, then audio scaling
	assign product   = PW'(mul_a_q * mul_b_q);
	assign level_sum = {1'b0, base_q} + {1'b0, quotient};

	adsr_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    (product[adsr_pkg::NUM_W-1:0]),
		.divisor  (divisor_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= adsr_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state and handshake outputs
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		div_start = 1'b0;
		case (state_q)
			adsr_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (elapsed_nxt == adsr_pkg::TIME_MAX)
						state_d = adsr_pkg::ST_SCALE;
					else
						state_d = adsr_pkg::ST_SEG;
				end
			end
			adsr_pkg::ST_SEG: begin
				if (seg_hit) begin
					if (seg_q == adsr_pkg::SEG_HOLD)
						state_d = adsr_pkg::ST_SCALE;
					else
						state_d = adsr_pkg::ST_NUM_MUL;
				end else if (seg_q == adsr_pkg::SEG_RELEASE) begin
					state_d = adsr_pkg::ST_SCALE;
				end
			end
			adsr_pkg::ST_NUM_MUL: begin
				div_start = 1'b1;
				state_d   = adsr_pkg::ST_DIV;
			end
			adsr_pkg::ST_DIV: begin
				if (div_done)
					state_d = adsr_pkg::ST_SCALE;
			end
			adsr_pkg::ST_SCALE: state_d = adsr_pkg::ST_DONE;
			adsr_pkg::ST_DONE: begin
				if (out_free)
					state_d = adsr_pkg::ST_IDLE;
			end
			default: state_d = adsr_pkg::ST_IDLE;
		endcase
	end

	// working registers of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			adsr_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					t_q     <= elapsed_nxt;
					seg_q   <= adsr_pkg::SEG_ATTACK;
					audio_q <= s_tdata[31:16];
					// saturated counter: silent level
					mul_a_q <= (TB+1)'(signed'(s_tdata[31:16]));
					mul_b_q <= '0;
				end
			end
			adsr_pkg::ST_SEG: begin
				if (seg_hit) begin
					divisor_q <= len_sel;
					case (seg_q)
						adsr_pkg::SEG_ATTACK: begin
							mul_a_q <= {1'b0, t_q};
							mul_b_q <= {1'b0, adsr_pkg::ONE_Q15};
							base_q  <= '0;
						end
						adsr_pkg::SEG_DECAY: begin
							mul_a_q <= {1'b0, len_sel - t_q};
							mul_b_q <= {1'b0, adsr_pkg::ONE_Q15 - sus_q};
							base_q  <= sus_q;
						end
						adsr_pkg::SEG_RELEASE: begin
							mul_a_q <= {1'b0, len_sel - t_q};
							mul_b_q <= {1'b0, sus_q};
							base_q  <= '0;
						end
						default: begin
							// sustain: flat level, scale the audio directly
							mul_a_q <= (TB+1)'(signed'(audio_q));
							mul_b_q <= {1'b0, sus_q};
						end
					endcase
				end else begin
					t_q <= t_q - len_sel;
					if (seg_q == adsr_pkg::SEG_RELEASE) begin
						mul_a_q <= (TB+1)'(signed'(audio_q));
						mul_b_q <= '0;
					end else begin
						seg_q <= adsr_pkg::seg_t'(seg_q + 2'd1);
					end
				end
			end
			adsr_pkg::ST_DIV: begin
				if (div_done) begin
					mul_a_q <= (TB+1)'(signed'(audio_q));
					mul_b_q <= {1'b0, level_sum[LW-1:0]};
				end
			end
			adsr_pkg::ST_SCALE: prod_q <= product;
			default: ;
		endcase
	end

	// output register: level and floor(audio * level / 2^15)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == adsr_pkg::ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == adsr_pkg::ST_DONE && out_free) begin
			out_level_q <= mul_b_q[LW-1:0];
			out_audio_q <= prod_q[LW+14:15];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_audio_q, out_level_q};

	// checks
	`ADSR_ASSERT_NXT(a_busy_after_beat, in_beat, !s_tready)
	`ADSR_ASSERT_IMP(a_level_max, m_tvalid, m_tdata[15:0] <= adsr_pkg::ONE_Q15)
	`ADSR_ASSERT_IMP(a_silent_at_zero, m_tvalid && (m_tdata[15:0] == '0), m_tdata[31:16] == '0)
	`ADSR_ASSERT_IMP(a_div_only_in_div, div_done, state_q == adsr_pkg::ST_DIV)

endmodule
`default_nettype wire

[tb/sv/adsr_envelope_generator_tb.sv]
// Self-checking stream testbench for the ADSR envelope generator.
module adsr_envelope_generator_tb;
	import adsr_pkg::*;

	localparam int HANG_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 64;
	localparam int PHASE_ITEMS  = 90;
	localparam int PHASE_COUNT  = 10;
	localparam int RUN_CAP      = 40;
	localparam int LONG_HOLD    = 200;
	// indexes past the last register, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_RELEASE + 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = {CFG_IDX_W{1'b1}};

	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic [15:0]      audio;
	} env_out_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [31:0]          s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [31:0]          m_tdata;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TIME_BITS-1:0] cfg_data;

	// predictor copy of registers and state
	logic [TIME_BITS-1:0] atk_len;
	logic [TIME_BITS-1:0] dec_len;
	logic [TIME_BITS-1:0] sus_len;
	logic [TIME_BITS-1:0] rel_len;
	logic [LVL_W-1:0]     sus_level;
	logic [TIME_BITS-1:0] sample_cnt;
	logic                 gate_was_high;

	env_out_t env_out_q[$];
	int       mismatch_cnt;
	int       rx_hold_cycles;
	bit       no_gaps;

	adsr_envelope_generator i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// piecewise-linear level at sample count t
	function automatic logic [LVL_W-1:0] level_at(logic [TIME_BITS-1:0] t);
		longint unsigned u, a, d, h, r, s;
		a = atk_len;
		d = dec_len;
		h = sus_len;
		r = rel_len;
		s = (sus_level > ONE_Q15) ? ONE_Q15 : sus_level;
		u = t;
		if (t == TIME_MAX) return '0;
		if (u < a) return LVL_W'(u * 64'(ONE_Q15) / a);
		u -= a;
		if (u < d) return LVL_W'(s + (d - u) * (64'(ONE_Q15) - s) / d);
		u -= d;
		if (u < h) return LVL_W'(s);
		u -= h;
		if (u < r) return LVL_W'((r - u) * s / r);
		return '0;
	endfunction

	// one audio tick: counter update, level, scaled sample
	function automatic env_out_t advance_envelope(logic signed [15:0] trig,
			logic signed [15:0] audio);
		env_out_t res;
		logic     gate;
		longint   prod;
		gate = trig > 0;
		if (sample_cnt != TIME_MAX) sample_cnt++;
		if (gate && !gate_was_high) sample_cnt = '0;
		gate_was_high = gate;
		res.level = level_at(sample_cnt);
		prod = longint'(audio) * longint'({1'b0, res.level});
		res.audio = 16'(prod >>> 15);
		return res;
	endfunction

	// idle length: mostly none, some short, a few long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (no_gaps || roll < 60) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [TIME_BITS-1:0] pick_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 12) return '0;
		if (roll < 80) return TIME_BITS'($urandom_range(1, 12));
		if (roll < 92) return TIME_BITS'($urandom_range(13, 300));
		if (roll < 96) return TIME_MAX;
		return TIME_BITS'($urandom);
	endfunction

	// sustain word: junk in the unused top bits, sometimes above one
	function automatic logic [TIME_BITS-1:0] pick_level_word();
		int                   roll;
		logic [TIME_BITS-1:0] word;
		roll = $urandom_range(0, 99);
		word = TIME_BITS'($urandom);
		if (roll < 15) word[LVL_W-1:0] = '0;
		else if (roll < 30) word[LVL_W-1:0] = ONE_Q15;
		else if (roll < 45) word[LVL_W-1:0] = LVL_W'($urandom_range(32769, 65535));
		else word[LVL_W-1:0] = LVL_W'($urandom_range(0, 32768));
		return word;
	endfunction

	// one register beat; cfg_valid stays up for a following write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_ATTACK:  atk_len = data;
			CFG_DECAY:   dec_len = data;
			CFG_HOLD:    sus_len = data;
			CFG_LEVEL:   sus_level = data[LVL_W-1:0];
			CFG_RELEASE: rel_len = data;
			default: ;
		endcase
	endtask

	task automatic program_envelope(input logic [TIME_BITS-1:0] a, d, h, lvl, r,
			input bit spare);
		write_reg(CFG_ATTACK, a);
		write_reg(CFG_DECAY, d);
		write_reg(CFG_HOLD, h);
		write_reg(CFG_LEVEL, lvl);
		write_reg(CFG_RELEASE, r);
		if (spare) begin
			for (int i = CFG_SPARE_LO; i <= CFG_SPARE_HI; i++)
				write_reg(CFG_IDX_W'(i), TIME_BITS'($urandom));
		end
		cfg_valid <= 1'b0;
	endtask

	// one input beat; valid is left high so back-to-back beats need no edge
	task automatic send_sample(input logic signed [15:0] trig, input logic signed [15:0] audio);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {audio, trig};
		do @(posedge clk); while (!s_tready);
		env_out_q.insert(env_out_q.size(), advance_envelope(trig, audio));
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (env_out_q.size() != 0) @(posedge clk);
	endtask

	// saturated counter gives silence; then a trigger under the reset lengths
	task automatic test_reset_silence();
		send_sample(-16'sd32768, 16'sd32767);
		send_sample(16'sd0, -16'sd32768);
		send_sample(-16'sd1, 16'sd1);
		send_sample(16'sd32767, 16'sd32767);
		send_sample(16'sd1, -16'sd32768);
		send_sample(16'sd12345, -16'sd1);
		drain_results();
	endtask

	// walk attack, decay, sustain, release and silence with masked level
	task automatic test_segment_walk();
		program_envelope(20'd3, 20'd4, 20'd2, 20'hA3039, 20'd5, 1'b1);
		send_sample(-16'sd32768, 16'sh5555);
		send_sample(16'sd1, 16'sd32767);
		for (int k = 1; k <= 14; k++)
			send_sample(16'sd32767, (k % 2) ? -16'sd32768 : 16'sd32767);
		send_sample(16'sd0, 16'shAAAA);
		send_sample(16'sd100, -16'sd1);
		drain_results();
	endtask

	// empty ramps are skipped, sustain word above one is held at one
	task automatic test_zero_lengths_and_clamp();
		program_envelope('0, '0, 20'd2, 20'h0FFFF, '0, 1'b0);
		send_sample(16'sd0, 16'sd1);
		send_sample(16'sd32767, 16'sd32767);
		send_sample(16'sd32767, -16'sd32768);
		send_sample(16'sd1, 16'sh7FFF);
		drain_results();
	endtask

	// receiver holds off while the sender keeps offering back to back
	task automatic test_output_backpressure();
		program_envelope(20'd2, 20'd6, 20'd4, 20'd30000, 20'd8, 1'b0);
		no_gaps = 1'b1;
		rx_hold_cycles = LONG_HOLD;
		send_sample(-16'sd5, 16'($urandom));
		repeat (15) send_sample(16'($urandom_range(1, 32767)), 16'($urandom));
		no_gaps = 1'b0;
		drain_results();
	endtask

	// gate bursts with random content under all-zero, all-maximum and random settings, plus noise
	task automatic test_random_envelopes();
		int     sent;
		int     roll;
		int     span;
		int     hi_run;
		int     lo_run;
		longint total;
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			if (phase == 0) begin
				program_envelope('0, '0, '0, '0, '0, 1'b1);
			end else if (phase == 1) begin
				program_envelope(TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, 1'b0);
			end else begin
				program_envelope(pick_len(), pick_len(), pick_len(), pick_level_word(),
					pick_len(), $urandom_range(0, 1));
			end
			no_gaps = (phase % 4 == 3);
			total = longint'(atk_len) + dec_len + sus_len + rel_len;
			span = (total > RUN_CAP) ? RUN_CAP + 2 : int'(total) + 2;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				roll = $urandom_range(0, 99);
				if (roll < 15) begin
					send_sample(16'($urandom), 16'($urandom));
					sent++;
				end else begin
					hi_run = $urandom_range(1, span);
					lo_run = $urandom_range(1, span);
					repeat (hi_run)
						send_sample(16'($urandom_range(1, 32767)), 16'($urandom));
					repeat (lo_run)
						send_sample(16'(-int'($urandom_range(0, 32768))), 16'($urandom));
					sent += hi_run + lo_run;
				end
			end
			no_gaps = 1'b0;
			drain_results();
		end
	endtask

	// output sink with random stalls and a requested long hold
	initial begin
		int quiet;
		quiet = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_cycles > 0) begin
				quiet = rx_hold_cycles;
				rx_hold_cycles = 0;
			end
			if (quiet > 0) begin
				m_tready <= 1'b0;
				quiet--;
			end else begin
				m_tready <= 1'b1;
				quiet = pick_gap();
			end
		end
	end

	// compare each result beat against the oldest prediction
	always @(posedge clk) begin
		env_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (env_out_q.size() == 0) begin
				$error("result beat with no sample pending: envelope_level %0d audio_out %0d",
					m_tdata[15:0], $signed(m_tdata[31:16]));
				mismatch_cnt++;
			end else begin
				want = env_out_q.pop_front();
				if (m_tdata[15:0] !== want.level) begin
					$error("envelope_level: expected %0d, got %0d", want.level, m_tdata[15:0]);
					mismatch_cnt++;
				end
				if (m_tdata[31:16] !== want.audio) begin
					$error("audio_out: expected %0d, got %0d", $signed(want.audio),
						$signed(m_tdata[31:16]));
					mismatch_cnt++;
				end
			end
		end
	end

	// hang detection: cycles without any beat on any channel
	initial begin
		int stuck;
		stuck = 0;
		wait (arst_n === 1'b1);
		while (stuck < HANG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				stuck = 0;
			else
				stuck++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_ATTACK;
		cfg_data  <= '0;
		mismatch_cnt   = 0;
		rx_hold_cycles = 0;
		no_gaps        = 1'b0;
		atk_len       = ATTACK_RST;
		dec_len       = DECAY_RST;
		sus_len       = HOLD_RST;
		sus_level     = LEVEL_RST;
		rel_len       = RELEASE_RST;
		sample_cnt    = TIME_MAX;
		gate_was_high = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_silence();
		test_segment_walk();
		test_zero_lengths_and_clamp();
		test_output_backpressure();
		test_random_envelopes();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && env_out_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/adsr_pkg.sv
rtl/adsr_divider.sv
rtl/adsr_envelope_generator.sv
tb/sv/adsr_envelope_generator_tb.sv
